@@ design/vrrq_pkg.sv @@
// Package for the variable-length record ring queue.
// Holds the item types, status and kind codes and the parameter defaults.
// No dependencies; vrrq_ctrl and the top level refer to it by scoped names.
package vrrq_pkg;

    // Parameter defaults for the top level.
    localparam int RING_BYTES_DEF   = 1024;
    localparam int HEADER_BYTES_DEF = 1;
    localparam int MAX_RECORD_DEF   = 64;

    // Fixed field widths.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 3;
    localparam int FILL_W = 11;

    // Request kinds.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_PUSH_OK  = 3'd0;
    localparam logic [STAT_W-1:0] ST_PUSH_REJ = 3'd1;
    localparam logic [STAT_W-1:0] ST_DATA     = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] ST_ZERO_LEN = 3'd4;

    // One input item.
    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  record_len;
        logic              first;
        logic              last;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  out_len;
        logic              end_of_record;
        logic [FILL_W-1:0] fill_bytes;
    } rsp_t;

endpackage

@@ design/vrrq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; used for the record ring storage.
module vrrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ design/vrrq_ctrl.sv @@
// Sequencer of the record ring queue: pointers, occupancy and the push and pop flows.
// Drives the ring RAM ports and offers one result item at a time.
// Depends on vrrq_pkg.
module vrrq_ctrl #(
    parameter int RING_BYTES   = vrrq_pkg::RING_BYTES_DEF,
    parameter int HEADER_BYTES = vrrq_pkg::HEADER_BYTES_DEF,
    parameter int MAX_RECORD   = vrrq_pkg::MAX_RECORD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  vrrq_pkg::req_t                req,
    input  logic                          req_valid,
    output logic                          req_stall,
    output vrrq_pkg::rsp_t                res,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic                          ram_we,
    output logic [$clog2(RING_BYTES)-1:0] ram_waddr,
    output logic [vrrq_pkg::BYTE_W-1:0]   ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(RING_BYTES)-1:0] ram_raddr,
    input  logic [vrrq_pkg::BYTE_W-1:0]   ram_rdata
);

    localparam int PW     = $clog2(RING_BYTES);
    localparam int OW     = $clog2(RING_BYTES + 1);
    localparam int CW     = ((OW > vrrq_pkg::BYTE_W) ? OW : vrrq_pkg::BYTE_W) + 1;
    localparam int HIW    = $clog2(HEADER_BYTES + 1);
    localparam int LEN_W  = vrrq_pkg::LEN_W;
    localparam int BYTE_W = vrrq_pkg::BYTE_W;
    localparam int FILL_W = vrrq_pkg::FILL_W;

    localparam logic [PW:0]       RB_W     = RING_BYTES[PW:0];
    localparam logic [PW:0]       HB_OFF   = HEADER_BYTES[PW:0];
    localparam logic [PW:0]       ONE_OFF  = {{PW{1'b0}}, 1'b1};
    localparam logic [LEN_W-1:0]  MAX_LEN  = MAX_RECORD[LEN_W-1:0];
    localparam logic [BYTE_W-1:0] MAX_BYTE = MAX_RECORD[BYTE_W-1:0];
    localparam logic [HIW-1:0]    HDR_LAST = HIW'(HEADER_BYTES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_TAIL,
        S_POP_HDR,
        S_POP_DATA
    } state_t;

    state_t            state_reg,    state_next;
    logic [PW-1:0]     read_ptr_reg, read_ptr_next;
    logic [PW-1:0]     write_ptr_reg, write_ptr_next;
    logic [OW-1:0]     occ_reg,      occ_next;
    logic [LEN_W-1:0]  push_pos_reg, push_pos_next;
    logic              dropping_reg, dropping_next;
    logic [LEN_W-1:0]  open_len_reg, open_len_next;
    logic [PW-1:0]     dat_ptr_reg,  dat_ptr_next;
    logic [HIW-1:0]    hdr_idx_reg,  hdr_idx_next;
    logic [BYTE_W-1:0] held_byte_reg, held_byte_next;
    logic              held_last_reg, held_last_next;
    logic [PW-1:0]     pop_ptr_reg,  pop_ptr_next;
    logic [LEN_W-1:0]  pop_len_reg,  pop_len_next;
    logic [LEN_W-1:0]  pop_cnt_reg,  pop_cnt_next;

    logic              accept;
    logic              do_data;
    logic [BYTE_W-1:0] d_byte;
    logic              d_last;
    logic [LEN_W-1:0]  pos_inc;
    logic [CW-1:0]     free_c;
    logic [CW-1:0]     need_c;
    logic              reject;
    logic [LEN_W-1:0]  hdr_len;
    logic [PW-1:0]     pop_next_ptr;

    // Ring address: base plus an offset that stays below the ring size.
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] base,
                                               input logic [PW:0] off);
        logic [PW:0] sum;
        sum = {1'b0, base} + off;
        if (sum >= RB_W)
        begin
            sum = sum - RB_W;
        end
        return sum[PW-1:0];
    endfunction

    // Input items are taken only in idle with room for a result item.
    assign accept    = req_valid && (state_reg == S_IDLE) && res_ready;
    assign req_stall = !((state_reg == S_IDLE) && res_ready);

    // Admission check for a new record.
    assign free_c = CW'(RING_BYTES) - CW'(occ_reg);
    assign need_c = CW'(req.record_len) + CW'(HEADER_BYTES);
    assign reject = (req.record_len > MAX_LEN) || (free_c < need_c);

    // Stored header, limited to the longest legal record.
    assign hdr_len = (ram_rdata > MAX_BYTE) ? MAX_LEN : ram_rdata[LEN_W-1:0];

    assign pos_inc      = push_pos_reg + LEN_W'(1);
    assign pop_next_ptr = wrap_add(pop_ptr_reg, ONE_OFF);

    // Next-state logic for the push and pop flows.
    always_comb
    begin
        state_next     = state_reg;
        read_ptr_next  = read_ptr_reg;
        write_ptr_next = write_ptr_reg;
        occ_next       = occ_reg;
        push_pos_next  = push_pos_reg;
        dropping_next  = dropping_reg;
        open_len_next  = open_len_reg;
        dat_ptr_next   = dat_ptr_reg;
        hdr_idx_next   = hdr_idx_reg;
        held_byte_next = held_byte_reg;
        held_last_next = held_last_reg;
        pop_ptr_next   = pop_ptr_reg;
        pop_len_next   = pop_len_reg;
        pop_cnt_next   = pop_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        res_valid      = 1'b0;
        res            = '0;
        do_data        = 1'b0;
        d_byte         = req.data_byte;
        d_last         = req.last;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == vrrq_pkg::KIND_POP)
                    begin
                        if (occ_reg == '0)
                        begin
                            res_valid         = 1'b1;
                            res.status        = vrrq_pkg::ST_EMPTY;
                            res.end_of_record = 1'b1;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = read_ptr_reg;
                            state_next = S_POP_HDR;
                        end
                    end
                    else if (req.first)
                    begin
                        push_pos_next = '0;
                        dropping_next = 1'b0;
                        if (reject)
                        begin
                            dropping_next     = 1'b1;
                            res_valid         = 1'b1;
                            res.status        = vrrq_pkg::ST_PUSH_REJ;
                            res.end_of_record = 1'b1;
                        end
                        else
                        begin
                            // Low header byte now; upper header bytes are zero.
                            ram_we         = 1'b1;
                            ram_waddr      = write_ptr_reg;
                            ram_wdata      = BYTE_W'(req.record_len);
                            open_len_next  = req.record_len;
                            dat_ptr_next   = wrap_add(write_ptr_reg, HB_OFF);
                            held_byte_next = req.data_byte;
                            held_last_next = req.last;
                            hdr_idx_next   = HIW'(1);
                            state_next     = (HEADER_BYTES > 1) ? S_HDR : S_TAIL;
                        end
                    end
                    else if (!dropping_reg && (push_pos_reg != '0))
                    begin
                        do_data = 1'b1;
                    end
                end
            end

            S_HDR:
            begin
                ram_we    = 1'b1;
                ram_waddr = wrap_add(write_ptr_reg, (PW+1)'(hdr_idx_reg));
                ram_wdata = '0;
                if (hdr_idx_reg == HDR_LAST)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + HIW'(1);
                end
            end

            S_TAIL:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                    if (open_len_reg == '0)
                    begin
                        // Header-only record commits at once.
                        write_ptr_next    = dat_ptr_reg;
                        occ_next          = occ_reg + OW'(HEADER_BYTES);
                        res_valid         = 1'b1;
                        res.status        = vrrq_pkg::ST_PUSH_OK;
                        res.end_of_record = 1'b1;
                    end
                    else
                    begin
                        do_data = 1'b1;
                        d_byte  = held_byte_reg;
                        d_last  = held_last_reg;
                    end
                end
            end

            S_POP_HDR:
            begin
                if (res_ready)
                begin
                    occ_next = occ_reg - OW'(HEADER_BYTES) - OW'(hdr_len);
                    if (hdr_len == '0)
                    begin
                        read_ptr_next     = wrap_add(read_ptr_reg, HB_OFF);
                        res_valid         = 1'b1;
                        res.status        = vrrq_pkg::ST_ZERO_LEN;
                        res.end_of_record = 1'b1;
                        state_next        = S_IDLE;
                    end
                    else
                    begin
                        pop_ptr_next = wrap_add(read_ptr_reg, HB_OFF);
                        ram_re       = 1'b1;
                        ram_raddr    = wrap_add(read_ptr_reg, HB_OFF);
                        pop_len_next = hdr_len;
                        pop_cnt_next = LEN_W'(1);
                        state_next   = S_POP_DATA;
                    end
                end
            end

            S_POP_DATA:
            begin
                // One stored byte per cycle while res_ready is high; the next read goes out as this one leaves.
                if (res_ready)
                begin
                    res_valid         = 1'b1;
                    res.status        = vrrq_pkg::ST_DATA;
                    res.out_byte      = ram_rdata;
                    res.out_len       = pop_len_reg;
                    res.end_of_record = (pop_cnt_reg == pop_len_reg);
                    if (pop_cnt_reg == pop_len_reg)
                    begin
                        read_ptr_next = pop_next_ptr;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        pop_ptr_next = pop_next_ptr;
                        ram_re       = 1'b1;
                        ram_raddr    = pop_next_ptr;
                        pop_cnt_next = pop_cnt_reg + LEN_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Store one data byte of the open record, then commit or abort.
        if (do_data)
        begin
            ram_we    = 1'b1;
            ram_waddr = dat_ptr_reg;
            ram_wdata = d_byte;
            if (pos_inc >= open_len_reg)
            begin
                write_ptr_next    = wrap_add(dat_ptr_reg, ONE_OFF);
                occ_next          = occ_reg + OW'(HEADER_BYTES) + OW'(open_len_reg);
                push_pos_next     = '0;
                res_valid         = 1'b1;
                res.status        = vrrq_pkg::ST_PUSH_OK;
                res.end_of_record = 1'b1;
            end
            else if (d_last)
            begin
                push_pos_next     = '0;
                res_valid         = 1'b1;
                res.status        = vrrq_pkg::ST_PUSH_REJ;
                res.end_of_record = 1'b1;
            end
            else
            begin
                push_pos_next = pos_inc;
                dat_ptr_next  = wrap_add(dat_ptr_reg, ONE_OFF);
            end
        end

        res.fill_bytes = FILL_W'(occ_next);
    end

    // State and sequencer registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            read_ptr_reg  <= '0;
            write_ptr_reg <= '0;
            occ_reg       <= '0;
            push_pos_reg  <= '0;
            dropping_reg  <= 1'b0;
            open_len_reg  <= '0;
            dat_ptr_reg   <= '0;
            hdr_idx_reg   <= '0;
            held_byte_reg <= '0;
            held_last_reg <= 1'b0;
            pop_ptr_reg   <= '0;
            pop_len_reg   <= '0;
            pop_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            read_ptr_reg  <= read_ptr_next;
            write_ptr_reg <= write_ptr_next;
            occ_reg       <= occ_next;
            push_pos_reg  <= push_pos_next;
            dropping_reg  <= dropping_next;
            open_len_reg  <= open_len_next;
            dat_ptr_reg   <= dat_ptr_next;
            hdr_idx_reg   <= hdr_idx_next;
            held_byte_reg <= held_byte_next;
            held_last_reg <= held_last_next;
            pop_ptr_reg   <= pop_ptr_next;
            pop_len_reg   <= pop_len_next;
            pop_cnt_reg   <= pop_cnt_next;
        end
    end

endmodule

@@ design/variable_record_ring_queue.sv @@
// Variable-length record ring queue. A push data byte is written as it is taken; a first item
// writes the header bytes in turn through the single RAM write port, then its data byte if any.
// A pop reads the header, then one record byte per cycle from the RAM read port while the output
// is not stalled; an empty pop answers at once. Each result item appears in the cycle after it is
// formed, in an output register; while it waits there under a stall, input items are held off.
// Reset clears pointers, occupancy and the open-record state at once; ring storage is not cleared.
module variable_record_ring_queue #(
    parameter int RING_BYTES   = vrrq_pkg::RING_BYTES_DEF,
    parameter int HEADER_BYTES = vrrq_pkg::HEADER_BYTES_DEF,
    parameter int MAX_RECORD   = vrrq_pkg::MAX_RECORD_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  vrrq_pkg::req_t req,
    input  logic           req_valid,
    output logic           req_stall,
    output vrrq_pkg::rsp_t rsp,
    output logic           rsp_valid,
    input  logic           rsp_stall
);

    localparam int PW = $clog2(RING_BYTES);

    vrrq_pkg::rsp_t              res;
    logic                        res_valid;
    logic                        res_ready;
    logic                        ram_we;
    logic [PW-1:0]               ram_waddr;
    logic [vrrq_pkg::BYTE_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [PW-1:0]               ram_raddr;
    logic [vrrq_pkg::BYTE_W-1:0] ram_rdata;
    vrrq_pkg::rsp_t              rsp_reg;
    logic                        rsp_valid_reg;

    // Ring storage.
    vrrq_ram #(
        .WIDTH (vrrq_pkg::BYTE_W),
        .DEPTH (RING_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Push and pop sequencer.
    vrrq_ctrl #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_RECORD   (MAX_RECORD)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Output register: a new item may enter when the slot is empty or being taken.
    assign res_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (res_valid)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= res;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

`ifndef SYNTHESIS
    // The sequencer never offers an item that the output register cannot take.
    a_res_fits: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result offered while output register is full");

    // A data byte always belongs to a record of non-zero length.
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == vrrq_pkg::ST_DATA)) |-> (rsp.out_len != '0))
        else $error("data byte with zero record length");

    // Status items are single and carry no byte or length.
    a_status_item: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != vrrq_pkg::ST_DATA))
            |-> (rsp.end_of_record && (rsp.out_byte == '0) && (rsp.out_len == '0)))
        else $error("malformed status item");

    // While a pop streams its record, no input item is taken.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> req_stall)
        else $error("input taken during a pop");
`endif

endmodule

@@ verif/variable_record_ring_queue_test.sv @@
// Self-checking testbench for the variable-length record ring queue.
// Depends on vrrq_pkg for the item types and codes, and on the top-level module.
// It carries its own queue predictor and checks every result item in order.
module variable_record_ring_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING      = vrrq_pkg::RING_BYTES_DEF;
    localparam int HDR       = vrrq_pkg::HEADER_BYTES_DEF;
    localparam int MAX_LEN   = vrrq_pkg::MAX_RECORD_DEF;
    localparam int HOLD_LEN  = 300;
    localparam int QUIET_MAX = 2000;
    localparam int TAIL_WAIT = 80;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    vrrq_pkg::req_t req       = '0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    vrrq_pkg::rsp_t rsp;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;

    // Predictor state: a copy of the ring and its pointers.
    logic [7:0]     ring_copy [RING];
    int unsigned    rd_ptr    = 0;
    int unsigned    wr_ptr    = 0;
    int unsigned    fill_cnt  = 0;
    int unsigned    open_cnt  = 0;
    bit             dropping  = 1'b0;
    vrrq_pkg::rsp_t expected_results [$];

    // Run bookkeeping.
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  fail_count    = 0;
    int  quiet_cycles  = 0;
    int  hold_requests = 0;
    bit  calm          = 1'b0;

    variable_record_ring_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall)
    );

    // Clock generation.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Queue an expected result carrying the current occupancy.
    function automatic void expect_result(logic [vrrq_pkg::STAT_W-1:0] st,
                                          logic [vrrq_pkg::BYTE_W-1:0] b,
                                          int unsigned len, bit eor);
        vrrq_pkg::rsp_t r;
        r.status        = st;
        r.out_byte      = b;
        r.out_len       = len[vrrq_pkg::LEN_W-1:0];
        r.end_of_record = eor;
        r.fill_bytes    = fill_cnt[vrrq_pkg::FILL_W-1:0];
        expected_results.push_back(r);
    endfunction

    // Length held in the header at a ring position, clamped to the record limit.
    function automatic int unsigned stored_len(int unsigned base);
        int unsigned len;
        len = 0;
        for (int i = HDR - 1; i >= 0; i--)
        begin
            len = (len << 8) | ring_copy[(base + i) % RING];
        end
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // Move the write pointer past a finished record and count its bytes.
    function automatic void commit_record(int unsigned len);
        wr_ptr   = (wr_ptr + HDR + len) % RING;
        fill_cnt = fill_cnt + HDR + len;
        open_cnt = 0;
    endfunction

    // Work out the results that one accepted item causes.
    function automatic void predict_queue_results(vrrq_pkg::req_t r);
        int unsigned len;
        if (r.kind == vrrq_pkg::KIND_POP)
        begin
            if (fill_cnt == 0)
            begin
                expect_result(vrrq_pkg::ST_EMPTY, '0, 0, 1'b1);
                return;
            end
            len      = stored_len(rd_ptr);
            fill_cnt = fill_cnt - HDR - len;
            if (len == 0)
            begin
                rd_ptr = (rd_ptr + HDR) % RING;
                expect_result(vrrq_pkg::ST_ZERO_LEN, '0, 0, 1'b1);
                return;
            end
            for (int unsigned i = 0; i < len; i++)
            begin
                expect_result(vrrq_pkg::ST_DATA, ring_copy[(rd_ptr + HDR + i) % RING], len,
                              i + 1 == len);
            end
            rd_ptr = (rd_ptr + HDR + len) % RING;
            return;
        end

        if (r.first)
        begin
            open_cnt = 0;
            dropping = 1'b0;
            if (r.record_len > MAX_LEN || RING - fill_cnt < r.record_len + HDR)
            begin
                dropping = 1'b1;
                expect_result(vrrq_pkg::ST_PUSH_REJ, '0, 0, 1'b1);
                return;
            end
            for (int i = 0; i < HDR; i++)
            begin
                ring_copy[(wr_ptr + i) % RING] = (i == 0) ? 8'(r.record_len) : 8'h00;
            end
            if (r.record_len == 0)
            begin
                commit_record(0);
                expect_result(vrrq_pkg::ST_PUSH_OK, '0, 0, 1'b1);
                return;
            end
        end
        else if (dropping || open_cnt == 0)
        begin
            return;
        end

        // Store the data byte of the open record.
        len = stored_len(wr_ptr);
        ring_copy[(wr_ptr + HDR + open_cnt) % RING] = r.data_byte;
        open_cnt++;
        if (open_cnt >= len)
        begin
            commit_record(len);
            expect_result(vrrq_pkg::ST_PUSH_OK, '0, 0, 1'b1);
        end
        else if (r.last)
        begin
            open_cnt = 0;
            expect_result(vrrq_pkg::ST_PUSH_REJ, '0, 0, 1'b1);
        end
    endfunction

    // Offer one item, with random idle cycles ahead of it outside the calm stretch, and wait until it is taken.
    task automatic send_item(vrrq_pkg::req_t r);
        while (!calm && $urandom_range(99) < 32)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        items_sent++;
        predict_queue_results(r);
    endtask

    function automatic vrrq_pkg::req_t make_push(logic [7:0] b, logic [6:0] len, bit f, bit l);
        vrrq_pkg::req_t r;
        r.kind       = vrrq_pkg::KIND_PUSH;
        r.data_byte  = b;
        r.record_len = len;
        r.first      = f;
        r.last       = l;
        return r;
    endfunction

    // Pop items carry random values in the fields the block ignores.
    function automatic vrrq_pkg::req_t make_pop();
        vrrq_pkg::req_t r;
        r.kind       = vrrq_pkg::KIND_POP;
        r.data_byte  = 8'($urandom);
        r.record_len = 7'($urandom);
        r.first      = 1'($urandom);
        r.last       = 1'($urandom);
        return r;
    endfunction

    // Send the first stop_at items of a record with random data, last set as asked.
    task automatic send_record(int len, int stop_at, bit last_at_stop);
        for (int i = 0; i < stop_at; i++)
        begin
            send_item(make_push(8'($urandom), (i == 0) ? 7'(len) : 7'($urandom),
                                i == 0, (i == stop_at - 1) ? last_at_stop : 1'b0));
        end
    endtask

    task automatic send_full_record(int len);
        send_record(len, (len == 0) ? 1 : len, 1'($urandom_range(1)));
    endtask

    // Empty pop, header-only record and its pop.
    task automatic test_empty_and_zero_length();
        send_item(make_pop());
        send_item(make_push(8'hFF, 7'd0, 1'b1, 1'b1));
        send_item(make_pop());
    endtask

    // Short records with extreme data bytes, popped back.
    task automatic test_record_bytes();
        send_item(make_push(8'h00, 7'd1, 1'b1, 1'b1));
        send_item(make_push(8'hFF, 7'd3, 1'b1, 1'b0));
        send_item(make_push(8'hA5, 7'd0, 1'b0, 1'b0));
        send_item(make_push(8'h5A, 7'd0, 1'b0, 1'b1));
        send_item(make_pop());
        send_item(make_pop());
    endtask

    // Too long, stray bytes, early last, restart and a pop while a record is open.
    task automatic test_broken_pushes();
        send_item(make_push(8'h11, 7'd65, 1'b1, 1'b0));
        send_item(make_push(8'h22, 7'd0, 1'b0, 1'b0));
        send_item(make_push(8'h33, 7'd0, 1'b0, 1'b1));
        send_item(make_push(8'h7F, 7'd2, 1'b1, 1'b0));
        send_item(make_push(8'h01, 7'd0, 1'b0, 1'b1));
        send_item(make_push(8'h55, 7'd0, 1'b0, 1'b0));
        send_item(make_push(8'hAA, 7'd4, 1'b1, 1'b0));
        send_item(make_push(8'hBB, 7'd0, 1'b0, 1'b1));
        send_item(make_push(8'hC1, 7'd5, 1'b1, 1'b0));
        send_item(make_push(8'hC2, 7'd0, 1'b0, 1'b0));
        send_item(make_push(8'hD1, 7'd2, 1'b1, 1'b0));
        send_item(make_push(8'hD2, 7'd0, 1'b0, 1'b0));
        send_item(make_push(8'hE1, 7'd3, 1'b1, 1'b0));
        send_item(make_pop());
        send_item(make_push(8'hE2, 7'd0, 1'b0, 1'b0));
        send_item(make_push(8'hE3, 7'd0, 1'b0, 1'b1));
        send_item(make_push(8'h00, 7'd127, 1'b1, 1'b1));
        send_item(make_pop());
        send_item(make_pop());
        send_item(make_pop());
    endtask

    // The receiver holds off for a long stretch while records and pops keep coming.
    task automatic test_backpressure();
        hold_requests++;
        for (int i = 0; i < 3; i++)
        begin
            send_full_record(20 + i);
        end
        for (int i = 0; i < 4; i++)
        begin
            send_item(make_pop());
        end
    endtask

    // Random traffic: mostly well-formed records and pops, some broken sequences.
    task automatic test_random_traffic(int target);
        int done;
        int sel;
        int len;
        int cut;
        done = 0;
        while (done < target)
        begin
            calm = (done >= 100 && done < 170);
            sel  = $urandom_range(99);
            len  = $urandom_range(99);
            len  = (len < 10) ? 0 : (len < 75) ? $urandom_range(8, 1) :
                   (len < 90) ? $urandom_range(32, 9) : $urandom_range(MAX_LEN, 33);
            if (sel < 35)
            begin
                send_item(make_pop());
                done++;
            end
            else if (sel < 80)
            begin
                send_full_record(len);
                done += (len == 0) ? 1 : len;
            end
            else if (sel < 88)
            begin
                // Early last on a record of at least two bytes.
                len = (len < 2) ? 2 : len;
                cut = $urandom_range(len - 1, 1);
                send_record(len, cut, 1'b1);
                done += cut;
            end
            else if (sel < 93)
            begin
                // Open record left unfinished; the next first item restarts.
                len = (len < 2) ? 2 : len;
                cut = $urandom_range(len - 1, 1);
                send_record(len, cut, 1'b0);
                done += cut;
            end
            else if (sel < 97)
            begin
                send_item(make_push(8'($urandom), 7'($urandom), 1'b0, 1'($urandom_range(1))));
            end
            else
            begin
                send_record($urandom_range(127, MAX_LEN + 1), $urandom_range(3, 1), 1'b1);
                done++;
            end
        end
        calm = 1'b0;
    endtask

    // Receiver: random stalls, a long counted hold-off on request.
    int hold_left  = 0;
    int holds_done = 0;
    always @(posedge clk)
    begin
        if (hold_requests != holds_done)
        begin
            holds_done++;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= !calm && ($urandom_range(99) < 32);
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        vrrq_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result item with nothing expected: %p", rsp);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    fail_count++;
                end
                if (rsp.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", want.out_byte, rsp.out_byte);
                    fail_count++;
                end
                if (rsp.out_len !== want.out_len)
                begin
                    $error("out_len: expected %0d, got %0d", want.out_len, rsp.out_len);
                    fail_count++;
                end
                if (rsp.end_of_record !== want.end_of_record)
                begin
                    $error("end_of_record: expected %0b, got %0b",
                           want.end_of_record, rsp.end_of_record);
                    fail_count++;
                end
                if (rsp.fill_bytes !== want.fill_bytes)
                begin
                    $error("fill_bytes: expected %0d, got %0d", want.fill_bytes, rsp.fill_bytes);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side ends the run.
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_and_zero_length();
        test_record_bytes();
        test_broken_pushes();
        test_backpressure();
        test_random_traffic(180);

        req_valid <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_WAIT) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_results.size());
            fail_count++;
        end
        $display("Sent %0d items and checked %0d results: empty and zero-length pops,",
                 items_sent, results_seen);
        $display("rejects, restarts, a long hold-off and random traffic.");
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/vrrq_pkg.sv
design/vrrq_ram.sv
design/vrrq_ctrl.sv
design/variable_record_ring_queue.sv
verif/variable_record_ring_queue_test.sv
